/* hw/rtl/hufd_pkg.sv */
// Shared constants, types and codes for the Huffman table bit decoder.
// No dependencies.
package hufd_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int MAX_CODE_LEN  = 32;

	localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int ACC_W   = MAX_CODE_LEN;
	localparam int ALEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int LCMP_W  = ALEN_W + 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 1'd1;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	localparam logic ST_SYMBOL   = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [31:0] code;
		logic [5:0]  len;
		logic [7:0]  sym;
	} entry_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic emit_need;
		logic out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/huffman_table_bit_decoder.sv */
// Top level of the bit-serial Huffman table decoder.
// Depends on hufd_pkg, hufd_ctrl, hufd_dp (which holds hufd_ram).
//
// A load beat is taken without stalling the input. A decode beat shifts the bit in
// on the accept cycle, then the code table is scanned one entry per cycle (up to
// entry_count, capped at the table size) through the registered read port of the
// table RAM, ending at the first hit or after the last entry. A result is then issued:
// a symbol on a hit, or an overflow when the accumulator holds MAX_CODE_LEN bits with
// no hit; otherwise no result is issued and the bits are kept for the next beat.
// The output register lets the next beat be accepted while a result still waits; a
// decode whose result finds the output register still full holds in its issue state
// until it drains. The table has no reset; only entries that were loaded may be
// searched.
module huffman_table_bit_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [7:0]                      entry_index,
	input  logic [31:0]                     code_value,
	input  logic [5:0]                      code_length,
	input  logic [7:0]                      entry_symbol,
	input  logic                            bit_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            status,
	output logic [7:0]                      symbol,
	output logic [15:0]                     row,
	output logic [15:0]                     column,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hufd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hufd_pkg::CFG_DATA_W-1:0] cfg_data
);

	hufd_pkg::ctl_cmd_t cmd;
	hufd_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	hufd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	hufd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.code_value   (code_value),
		.code_length  (code_length),
		.entry_symbol (entry_symbol),
		.bit_in       (bit_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.symbol       (symbol),
		.row          (row),
		.column       (column)
	);

endmodule

/* hw/rtl/hufd_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module hufd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/hufd_ctrl.sv */
// Sequencer for the decoder: accept, table scan, result issue.
// Depends on hufd_pkg.
module hufd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               req_type,
	output logic               in_stall,
	output hufd_pkg::ctl_cmd_t cmd,
	input  hufd_pkg::dp_stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load  = accept && (req_type == hufd_pkg::REQ_LOAD);
				cmd.start = accept && (req_type == hufd_pkg::REQ_DECODE);
				if (cmd.start) begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = stat.emit_need && stat.out_free;
				if (!stat.emit_need || stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/hufd_dp.sv */
// Datapath: code table RAM, bit accumulator, scan pointer, position counters,
// config registers and output register. Depends on hufd_pkg and hufd_ram.
module hufd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hufd_pkg::ctl_cmd_t                cmd,
	output hufd_pkg::dp_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic [hufd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hufd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                        entry_index,
	input  logic [31:0]                       code_value,
	input  logic [5:0]                        code_length,
	input  logic [7:0]                        entry_symbol,
	input  logic                              bit_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [7:0]                        symbol,
	output logic [15:0]                       row,
	output logic [15:0]                       column
);

	localparam int AW = hufd_pkg::ADDR_W;
	localparam int CW = hufd_pkg::CNT_W;
	localparam int QW = hufd_pkg::ACC_W;
	localparam int LW = hufd_pkg::ALEN_W;
	localparam int MW = hufd_pkg::LCMP_W;

	logic [8:0]    entry_count_q;
	logic [15:0]   row_bytes_q;
	logic [QW-1:0] acc_q;
	logic [LW-1:0] alen_q;
	logic [15:0]   row_q;
	logic [15:0]   col_q;
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic          hit_q;
	logic [7:0]    sym_q;
	logic          out_valid_q;
	logic          status_q;
	logic [7:0]    symbol_q;
	logic [15:0]   row_out_q;
	logic [15:0]   col_out_q;

	logic [CW-1:0]   limit;
	logic            issue;
	logic            tbl_we;
	hufd_pkg::entry_t wr_entry;
	hufd_pkg::entry_t rd_entry;
	logic [QW-1:0]   code_ext;
	logic [QW-1:0]   len_mask;
	logic            hit_now;
	logic            wrap;
	logic [15:0]     row_eff;
	logic [15:0]     col_eff;

	// table scan covers min(entry_count, table size)
	assign limit = (11'(entry_count_q) > 11'(hufd_pkg::TABLE_ENTRIES))
		? CW'(hufd_pkg::TABLE_ENTRIES) : CW'(entry_count_q);
	assign issue = cmd.scan && (scan_idx_q < limit);

	assign tbl_we = cmd.load && (9'(entry_index) < 9'(hufd_pkg::TABLE_ENTRIES));
	assign wr_entry.code = code_value;
	assign wr_entry.len  = code_length;
	assign wr_entry.sym  = entry_symbol;

	hufd_ram #(
		.WIDTH ($bits(hufd_pkg::entry_t)),
		.DEPTH (hufd_pkg::TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_index[AW-1:0]),
		.wdata (wr_entry),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (rd_entry)
	);

	assign code_ext = QW'(rd_entry.code);
	assign len_mask = (MW'(rd_entry.len) >= MW'(QW)) ? {QW{1'b1}}
		: ~({QW{1'b1}} << rd_entry.len);
	assign hit_now  = cmd.scan && rd_vld_s1
		&& (rd_entry.len != 6'd0)
		&& (MW'(rd_entry.len) == MW'(alen_q))
		&& ((code_ext & len_mask) == acc_q);

	assign stat.scan_done = hit_now || (!issue && !rd_vld_s1);
	assign stat.emit_need = hit_q || (MW'(alen_q) >= MW'(hufd_pkg::MAX_CODE_LEN));
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign wrap    = (col_q >= row_bytes_q);
	assign row_eff = wrap ? 16'(row_q + 16'd1) : row_q;
	assign col_eff = wrap ? 16'd0 : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			row_bytes_q   <= 16'd3;
			acc_q         <= '0;
			alen_q        <= '0;
			row_q         <= '0;
			col_q         <= '0;
			scan_idx_q    <= '0;
			rd_vld_s1     <= 1'b0;
			hit_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					hufd_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data[8:0];
					hufd_pkg::CFG_ROW_BYTES:   row_bytes_q   <= cfg_data;
					default: ;
				endcase
			end

			rd_vld_s1 <= issue && !hit_now;
			if (issue) begin
				scan_idx_q <= CW'(scan_idx_q + 1'b1);
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end

			if (cmd.load) begin
				acc_q  <= '0;
				alen_q <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end
			if (cmd.start) begin
				acc_q      <= {acc_q[QW-2:0], bit_in};
				alen_q     <= LW'(alen_q + 1'b1);
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				acc_q       <= '0;
				alen_q      <= '0;
				if (hit_q) begin
					row_q <= row_eff;
					col_q <= 16'(col_eff + 16'd1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) begin
			sym_q <= rd_entry.sym;
		end
		if (cmd.emit) begin
			if (hit_q) begin
				status_q  <= hufd_pkg::ST_SYMBOL;
				symbol_q  <= sym_q;
				row_out_q <= row_eff;
				col_out_q <= col_eff;
			end else begin
				status_q  <= hufd_pkg::ST_OVERFLOW;
				symbol_q  <= '0;
				row_out_q <= '0;
				col_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign symbol    = symbol_q;
	assign row       = row_out_q;
	assign column    = col_out_q;

endmodule

/* hw/rtl/hufd_checker.sv */
// Port-level checks for huffman_table_bit_decoder, bound to the top level.
// Depends on hufd_pkg.
module hufd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic        status,
	input logic [7:0]  symbol,
	input logic [15:0] row,
	input logic [15:0] column
);

	// a waiting result is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == hufd_pkg::ST_OVERFLOW)
			|-> (symbol == 8'd0) && (row == 16'd0) && (column == 16'd0))
		else $error("overflow beat carries nonzero fields");

	// a decode beat occupies the block for at least the scan
	a_dec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == hufd_pkg::REQ_DECODE) |=> in_stall)
		else $error("decode beat did not start a scan");

	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == hufd_pkg::REQ_LOAD) |=> !in_stall)
		else $error("load beat took more than one cycle");

endmodule

bind huffman_table_bit_decoder hufd_checker u_hufd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.symbol    (symbol),
	.row       (row),
	.column    (column)
);
